>>> rtl/core/qte_pkg.sv
// shared constants, types and functions for the quaternion to euler angle pipeline
package qte_pkg;

  localparam int QW = 16;
  localparam int OPW = 36;
  localparam int ACCW = 26;
  localparam int ITERS = 16;
  localparam int SQW = 57;
  localparam int SQRT_STEPS = 29;
  localparam int SQRT_PER_STG = 4;
  localparam int SQRT_STGS = 8;
  localparam logic signed [ACCW-1:0] HALF_PI = 26'sd4194304;
  localparam logic signed [OPW-1:0] Q_ONE = 36'sd268435456;

  typedef logic signed [OPW-1:0] op_t;
  typedef logic signed [ACCW-1:0] acc_t;

  typedef struct packed {
    op_t  x;
    op_t  y;
    acc_t acc;
    logic zero;
  } cstate_t;

  function automatic acc_t atan_entry(input logic [3:0] i);
    acc_t r;
    case (i)
      4'd0:  r = 26'sd2097152;
      4'd1:  r = 26'sd1238021;
      4'd2:  r = 26'sd654136;
      4'd3:  r = 26'sd332050;
      4'd4:  r = 26'sd166669;
      4'd5:  r = 26'sd83416;
      4'd6:  r = 26'sd41718;
      4'd7:  r = 26'sd20860;
      4'd8:  r = 26'sd10430;
      4'd9:  r = 26'sd5215;
      4'd10: r = 26'sd2608;
      4'd11: r = 26'sd1304;
      4'd12: r = 26'sd652;
      4'd13: r = 26'sd326;
      4'd14: r = 26'sd163;
      default: r = 26'sd81;
    endcase
    return r;
  endfunction

  function automatic cstate_t cordic_pre(input op_t y, input op_t x);
    cstate_t s;
    s.zero = (x == '0) && (y == '0);
    s.acc = '0;
    s.x = x;
    s.y = y;
    if (x < 0) begin
      if (y >= 0) begin
        s.x = y;
        s.y = -x;
        s.acc = HALF_PI;
      end else begin
        s.x = -y;
        s.y = x;
        s.acc = -HALF_PI;
      end
    end
    return s;
  endfunction

  function automatic cstate_t cordic_iter(input cstate_t s, input logic [3:0] i);
    cstate_t r;
    op_t dx;
    op_t dy;
    dx = s.y >>> i;
    dy = s.x >>> i;
    r = s;
    if (s.y >= 0) begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.acc = s.acc + atan_entry(i);
    end else begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.acc = s.acc - atan_entry(i);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] round_ang(input cstate_t s);
    acc_t a;
    a = s.zero ? '0 : s.acc + 26'sd128;
    return a[23:8];
  endfunction

endpackage

>>> rtl/core/quaternion_to_euler_angles.sv
// top level: quaternion to zyx roll, pitch and yaw, fully pipelined
//
// One quaternion enters per clock and one result leaves per clock unless the output
// stalls. The pipeline has 1 product stage, 1 sum stage, 1 radicand stage, 8 square
// root stages (4 result bits each, 1 in the last), 1 pre-rotation stage, 8 cordic
// stages (2 iterations each) and 1 rounding stage; the square root pipeline of the pitch
// path sets this depth, and roll and yaw ride along through matching delay.
// Every stage holds when the output register is full and not taken, so a stall
// loses nothing. Inputs are Q2.14, angles are binary angles with 32768 meaning
// pi. A sine argument beyond unit magnitude is saturated and flagged.
module quaternion_to_euler_angles (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32], pitch_clamped [48]
  output logic [55:0] out_tdata
);
  import qte_pkg::*;

  localparam int NS = 1 + 1 + 1 + SQRT_STGS + 1 + ITERS/2 + 1;

  // one shared advance: the whole pipe moves unless the last stage is stuck
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv = !(vld_r[NS-1] && !out_tready);
  assign in_tready = adv;
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // stage 0: products, exact in 32 bits
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];
  logic signed [31:0] p_yz_r, p_wx_r, p_xx_r, p_yy_r, p_xy_r, p_wz_r, p_zz_r, p_xz_r, p_wy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_yz_r <= qy * qz; p_wx_r <= qw * qx; p_xx_r <= qx * qx;
      p_yy_r <= qy * qy; p_xy_r <= qx * qy; p_wz_r <= qw * qz;
      p_zz_r <= qz * qz; p_xz_r <= qx * qz; p_wy_r <= qw * qy;
    end
  end

  // stage 1: atan2 operands and saturated sine argument
  op_t rn_r, rd_r, yn_r, yd_r, s_r;
  logic clamp_r;
  op_t s_raw;
  assign s_raw = (OPW'(p_xz_r) - OPW'(p_wy_r)) <<< 1;
  always_ff @(posedge clk) begin
    if (adv) begin
      rn_r <= (OPW'(p_yz_r) + OPW'(p_wx_r)) <<< 1;
      rd_r <= Q_ONE - ((OPW'(p_xx_r) + OPW'(p_yy_r)) <<< 1);
      yn_r <= (OPW'(p_xy_r) + OPW'(p_wz_r)) <<< 1;
      yd_r <= Q_ONE - ((OPW'(p_yy_r) + OPW'(p_zz_r)) <<< 1);
      clamp_r <= (s_raw > Q_ONE) || (s_raw < -Q_ONE);
      s_r <= (s_raw > Q_ONE) ? Q_ONE : ((s_raw < -Q_ONE) ? -Q_ONE : s_raw);
    end
  end

  // s^2 is up to 2^56, so the square root input is not formed from s^2 directly;
  // radicand 2^56 - s^2 computed from |s| <= 2^28 as (2^28-|s|)(2^28+|s|)
  logic [28:0] sabs;
  assign sabs = s_r[OPW-1] ? 29'(-s_r) : 29'(s_r);

  // square root pipeline: stage k does up to SQRT_PER_STG restoring steps, SQRT_STEPS in all
  logic [SQW-1:0] rem_r [SQRT_STGS+1];
  logic [SQRT_STEPS-1:0] root_r [SQRT_STGS+1];
  op_t rn_d [SQRT_STGS+1], rd_d [SQRT_STGS+1], yn_d [SQRT_STGS+1], yd_d [SQRT_STGS+1];
  op_t s_d [SQRT_STGS+1];
  logic clamp_d [SQRT_STGS+1];
  logic [58:0] rad_w;

  assign rad_w = 59'(30'(29'd268435456 - sabs)) * 59'(30'({1'b0, 29'd268435456} + 30'(sabs)));

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= rad_w[SQW-1:0];
      root_r[0] <= '0;
      rn_d[0] <= rn_r; rd_d[0] <= rd_r; yn_d[0] <= yn_r; yd_d[0] <= yd_r;
      s_d[0] <= s_r; clamp_d[0] <= clamp_r;
    end
  end

  for (genvar g = 0; g < SQRT_STGS; g++) begin : g_sqrt
    logic [SQW-1:0] rem_n;
    logic [SQRT_STEPS-1:0] root_n;
    always_comb begin
      logic [SQW+1:0] trial;
      rem_n = rem_r[g];
      root_n = root_r[g];
      for (int j = 0; j < SQRT_PER_STG; j++) begin
        if (g*SQRT_PER_STG + j < SQRT_STEPS) begin
          trial = ({2'b00, root_n, 1'b0, 1'b1} << (2*(SQRT_STEPS-1-(g*SQRT_PER_STG+j))));
          if ({2'b00, rem_n} >= trial) begin
            rem_n = rem_n - trial[SQW-1:0];
            root_n = {root_n[SQRT_STEPS-2:0], 1'b1};
          end else begin
            root_n = {root_n[SQRT_STEPS-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g+1] <= rem_n;
        root_r[g+1] <= root_n;
        rn_d[g+1] <= rn_d[g]; rd_d[g+1] <= rd_d[g];
        yn_d[g+1] <= yn_d[g]; yd_d[g+1] <= yd_d[g];
        s_d[g+1] <= s_d[g]; clamp_d[g+1] <= clamp_d[g];
      end
    end
  end

  // pre-rotation into the right half plane
  localparam int NC = ITERS/2;
  cstate_t cr_r [NC+1], cp_r [NC+1], cy_r [NC+1];
  logic clamp_c [NC+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      cr_r[0] <= cordic_pre(rn_d[SQRT_STGS], rd_d[SQRT_STGS]);
      cy_r[0] <= cordic_pre(yn_d[SQRT_STGS], yd_d[SQRT_STGS]);
      cp_r[0] <= cordic_pre(-s_d[SQRT_STGS], OPW'(root_r[SQRT_STGS]));
      clamp_c[0] <= clamp_d[SQRT_STGS];
    end
  end

  // cordic: two iterations per stage, three lanes
  for (genvar k = 0; k < NC; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        cr_r[k+1] <= cordic_iter(cordic_iter(cr_r[k], 4'(2*k)), 4'(2*k+1));
        cp_r[k+1] <= cordic_iter(cordic_iter(cp_r[k], 4'(2*k)), 4'(2*k+1));
        cy_r[k+1] <= cordic_iter(cordic_iter(cy_r[k], 4'(2*k)), 4'(2*k+1));
        clamp_c[k+1] <= clamp_c[k];
      end
    end
  end

  // rounding and pitch saturation into the output register
  logic signed [15:0] pr;
  logic signed [15:0] p_sat;
  acc_t pacc;
  always_comb begin
    pacc = cp_r[NC].zero ? '0 : cp_r[NC].acc + 26'sd128;
    pr = pacc[23:8];
    if ($signed(pacc[ACCW-1:8]) > 18'sd16384) p_sat = 16'sd16384;
    else if ($signed(pacc[ACCW-1:8]) < -18'sd16384) p_sat = -16'sd16384;
    else p_sat = pr;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {7'd0, clamp_c[NC], round_ang(cy_r[NC]), p_sat, round_ang(cr_r[NC])};
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipe stalled with empty output");
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:16]) <= 16'sd16384 &&
                    $signed(out_tdata[31:16]) >= -16'sd16384))
    else $error("pitch out of range");
`endif

endmodule
